// ===== sv/qdd_pkg.sv =====
package qdd_pkg;

   // Item opcodes.
   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_LOAD_AZ = 2'd1,
      OP_LOAD_EL = 2'd2,
      OP_IGNORE  = 2'd3
   } opcode_type;

   // Which rule set an axis follows.
   typedef enum logic {
      AXIS_AZ = 1'b0,
      AXIS_EL = 1'b1
   } axis_kind_type;

   // Noise-rejecting sequence states.
   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'd0,
      SEQ_FIRST  = 2'd1,
      SEQ_SECOND = 2'd2,
      SEQ_ARMED  = 2'd3
   } seq_type;

   // Counter values after reset, before they are cut to the counter width.
   localparam logic [31:0] AZ_RESET_COUNT = 32'd92571;
   localparam logic [31:0] EL_RESET_COUNT = 32'd90;

   // Per-axis controls for one word leaving the input register.
   typedef struct packed {
      logic step_en;
      logic load_en;
      logic a_edge;
      logic b_edge;
      logic a_level;
      logic b_level;
   } axis_ctrl_type;

   // Outcome of one channel edge.
   typedef struct packed {
      seq_type seq;
      logic    count_up;
      logic    count_down;
   } step_type;

   // Applies one edge of channel A or B to an axis sequence.
   function automatic step_type seq_step(axis_kind_type kind, seq_type seq,
                                         logic high, logic is_b);
      step_type r;
      r.seq        = seq;
      r.count_up   = 1'b0;
      r.count_down = 1'b0;
      if (high) begin
         if (seq == SEQ_IDLE) begin
            r.seq = SEQ_FIRST;
         end else if (kind == AXIS_AZ) begin
            r.seq = SEQ_SECOND;
         end else if (seq == SEQ_FIRST) begin
            r.seq = SEQ_SECOND;
         end else begin
            r.seq = SEQ_IDLE;
         end
      end else if (seq == SEQ_SECOND) begin
         r.seq = SEQ_ARMED;
      end else begin
         if (seq == SEQ_ARMED) begin
            // Azimuth counts down on A, elevation counts down on B.
            if ((kind == AXIS_AZ) != is_b) begin
               r.count_down = 1'b1;
            end else begin
               r.count_up = 1'b1;
            end
         end
         r.seq = SEQ_IDLE;
      end
      return r;
   endfunction

endpackage

// ===== sv/qdd_axis.sv =====
module qdd_axis #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  qdd_pkg::axis_kind_type kind,
   input  logic [COUNT_WIDTH-1:0] reset_count,
   input  qdd_pkg::axis_ctrl_type ctrl,
   input  logic signed [31:0]     load_value,
   output logic signed [31:0]     position_next
);
   import qdd_pkg::*;

   seq_type                       seq_ff;
   seq_type                       seq_in;
   logic signed [COUNT_WIDTH-1:0] counter_ff;
   logic signed [COUNT_WIDTH-1:0] counter_in;
   step_type                      step_a;
   step_type                      step_b;
   logic                          count_up;
   logic                          count_down;

   // Channel A edge first, then channel B from the state A left.
   always_comb begin
      step_a.seq        = seq_ff;
      step_a.count_up   = 1'b0;
      step_a.count_down = 1'b0;
      if (ctrl.a_edge) begin
         step_a = seq_step(kind, seq_ff, ctrl.a_level, 1'b0);
      end
      step_b = step_a;
      step_b.count_up   = 1'b0;
      step_b.count_down = 1'b0;
      if (ctrl.b_edge) begin
         step_b = seq_step(kind, step_a.seq, ctrl.b_level, 1'b1);
      end
      count_up   = step_a.count_up | step_b.count_up;
      count_down = step_a.count_down | step_b.count_down;
   end

   // Next counter and sequence values.
   always_comb begin
      seq_in     = seq_ff;
      counter_in = counter_ff;
      if (ctrl.load_en) begin
         counter_in = COUNT_WIDTH'(load_value);
      end else if (ctrl.step_en) begin
         seq_in = step_b.seq;
         if (count_up) begin
            counter_in = counter_ff + COUNT_WIDTH'(1);
         end else if (count_down) begin
            counter_in = counter_ff - COUNT_WIDTH'(1);
         end
      end
   end

   assign position_next = 32'(counter_in);

   // Sequence state and position counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= SEQ_IDLE;
         counter_ff <= reset_count;
      end else begin
         seq_ff     <= seq_in;
         counter_ff <= counter_in;
      end
   end

endmodule

// ===== sv/dual_quadrature_decoder.sv =====
// Dual quadrature decoder for an azimuth and an elevation encoder.
// The request channel (req_) carries one word per item: an opcode, the four
// encoder pin levels and a 32-bit signed load value. Opcode sample decodes
// the pin edges of both axes, the load opcodes overwrite one counter, and
// the ignored opcode changes nothing. Every word yields exactly one response
// word on the rsp_ channel with both positions and a load flag.
// A word accepted into the input register is decoded from there into the
// response register once that register is empty or its word is taken, and
// can then be taken from it. One word per cycle is sustained while
// rsp_stall stays low; the figure is set by the single decode step between
// the input register and the response register.
// The input register accepts a word while a response waits, so req_stall
// rises only when both the input and the response registers are full and
// rsp_stall is high. A stalled response holds its value.
// Reset clears both registers, the sequences and the stored pin levels and
// loads the counters with 92571 and 90. The first sample after reset only
// stores the pin levels; no edge is decoded from it.
module dual_quadrature_decoder #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic               req_az_chan_a,
   input  logic               req_az_chan_b,
   input  logic               req_el_chan_a,
   input  logic               req_el_chan_b,
   input  logic signed [31:0] req_load_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_az_position,
   output logic signed [31:0] rsp_el_position,
   output logic               rsp_load_ok
);
   import qdd_pkg::*;

   logic               in_valid_ff;
   logic               in_valid_in;
   opcode_type         in_opcode_ff;
   logic [3:0]         in_levels_ff;
   logic signed [31:0] in_load_ff;
   logic [3:0]         last_levels_ff;
   logic [3:0]         last_levels_in;
   logic               primed_ff;
   logic               primed_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [31:0] rsp_az_ff;
   logic signed [31:0] rsp_el_ff;
   logic               rsp_ok_ff;
   logic               advance;
   logic               take;
   logic               fire;
   logic               sample;
   logic               step_en;
   logic [3:0]         diff;
   axis_ctrl_type      az_ctrl;
   axis_ctrl_type      el_ctrl;
   logic signed [31:0] az_next;
   logic signed [31:0] el_next;

   // Handshake: the input register moves on whenever the response register is empty or its word is taken.
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = in_valid_ff && !advance;
   assign take        = req_valid && !req_stall;
   assign fire        = in_valid_ff && advance;
   assign in_valid_in = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   // Edge detection against the previous sample.
   assign sample         = fire && (in_opcode_ff == OP_SAMPLE);
   assign step_en        = sample && primed_ff;
   assign diff           = in_levels_ff ^ last_levels_ff;
   assign last_levels_in = sample ? in_levels_ff : last_levels_ff;
   assign primed_in      = primed_ff || sample;

   // Controls for the two axes.
   always_comb begin
      az_ctrl.step_en = step_en;
      az_ctrl.load_en = fire && (in_opcode_ff == OP_LOAD_AZ);
      az_ctrl.a_edge  = diff[0];
      az_ctrl.b_edge  = diff[1];
      az_ctrl.a_level = in_levels_ff[0];
      az_ctrl.b_level = in_levels_ff[1];
      el_ctrl.step_en = step_en;
      el_ctrl.load_en = fire && (in_opcode_ff == OP_LOAD_EL);
      el_ctrl.a_edge  = diff[2];
      el_ctrl.b_edge  = diff[3];
      el_ctrl.a_level = in_levels_ff[2];
      el_ctrl.b_level = in_levels_ff[3];
   end

   qdd_axis #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_az (
      .clock        (clock),
      .reset        (reset),
      .kind         (AXIS_AZ),
      .reset_count  (COUNT_WIDTH'(AZ_RESET_COUNT)),
      .ctrl         (az_ctrl),
      .load_value   (in_load_ff),
      .position_next(az_next)
   );

   qdd_axis #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_el (
      .clock        (clock),
      .reset        (reset),
      .kind         (AXIS_EL),
      .reset_count  (COUNT_WIDTH'(EL_RESET_COUNT)),
      .ctrl         (el_ctrl),
      .load_value   (in_load_ff),
      .position_next(el_next)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_levels_ff <= 4'd0;
         primed_ff      <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_levels_ff <= last_levels_in;
         primed_ff      <= primed_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (take) begin
         in_opcode_ff <= opcode_type'(req_opcode);
         in_levels_ff <= {req_el_chan_b, req_el_chan_a, req_az_chan_b, req_az_chan_a};
         in_load_ff   <= req_load_value;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_az_ff <= az_next;
         rsp_el_ff <= el_next;
         rsp_ok_ff <= (in_opcode_ff == OP_LOAD_AZ) || (in_opcode_ff == OP_LOAD_EL);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_az_position = rsp_az_ff;
   assign rsp_el_position = rsp_el_ff;
   assign rsp_load_ok     = rsp_ok_ff;

endmodule

// ===== sv/qdd_checker.sv =====
module qdd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_az_position,
   input logic signed [31:0] rsp_el_position,
   input logic               rsp_load_ok
);

   // Reset empties the block, so nothing is shown and nothing is held off.
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // The request side is only held off when a response waits on a stalled receiver.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   // A stalled response stays and keeps its word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_az_position)
         && $stable(rsp_el_position) && $stable(rsp_load_ok))
      else $error("stalled response changed");

   // Once a taken word has sat in the input register, a response is shown: its own or an older one still held.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("no response shown after an accepted word");

endmodule

bind dual_quadrature_decoder qdd_checker u_qdd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_az_position(rsp_az_position),
   .rsp_el_position(rsp_el_position),
   .rsp_load_ok    (rsp_load_ok)
);
